// ----- rtl/dtc_pkg.sv -----
// Shared types, widths and register codes of the depth-to-colour pixel mapper.
package dtc_pkg;

  // Field and register widths
  localparam int PIX_W      = 10;
  localparam int DEPTH_W    = 16;
  localparam int CDW        = 14;
  localparam int CCW        = 15;
  localparam int RATIO_W    = 16;
  localparam int SHX_W      = 24;
  localparam int SHZ_W      = 13;
  localparam int CRD_W      = 11;

  // Fraction bits of the principal points and of the focal ratios
  localparam int PT_FRAC    = 4;
  localparam int RATIO_FRAC = 12;

  // Datapath widths
  localparam int Z_W     = DEPTH_W + 2;            // signed shifted depth
  localparam int ZU_W    = DEPTH_W + 1;            // shifted depth once known positive
  localparam int OFFS_W  = PIX_W + PT_FRAC + 1;    // signed pixel offset, Q.4
  localparam int PROD_W  = OFFS_W + RATIO_W;       // offset times ratio
  localparam int PD_W    = PROD_W + DEPTH_W;       // times depth
  localparam int CZ_W    = CCW + ZU_W;             // colour centre times z
  localparam int NUM_W   = PD_W + 1;               // full signed numerator
  localparam int DEN_SH  = PT_FRAC + RATIO_FRAC + 1;  // divisor is z << DEN_SH
  localparam int DIVD_W  = NUM_W + 1;              // 2|num| + den
  localparam int NQ_W    = DIVD_W - DEN_SH;        // dividend once divided by 2^DEN_SH
  localparam int Q_W     = CRD_W;                  // quotient bits kept
  localparam int REM_W   = ZU_W + Q_W;             // remainder after overflow check

  // Pipeline depths
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = Q_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SHX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DPT_CTR_X = 3'd0,
    REG_DPT_CTR_Y = 3'd1,
    REG_CLR_CTR_X = 3'd2,
    REG_CLR_CTR_Y = 3'd3,
    REG_RATIO_X   = 3'd4,
    REG_RATIO_Y   = 3'd5,
    REG_SHIFT_X   = 3'd6,
    REG_SHIFT_Z   = 3'd7
  } dtc_reg_e;

  // Register reset values
  localparam logic [CDW-1:0]            RST_DPT_CTR_X = 14'd4096;
  localparam logic [CDW-1:0]            RST_DPT_CTR_Y = 14'd3392;
  localparam logic [CCW-1:0]            RST_CLR_CTR_X = 15'd15360;
  localparam logic [CCW-1:0]            RST_CLR_CTR_Y = 15'd8640;
  localparam logic [RATIO_W-1:0]        RST_RATIO_X   = 16'd11878;
  localparam logic [RATIO_W-1:0]        RST_RATIO_Y   = 16'd11878;
  localparam logic signed [SHX_W-1:0]   RST_SHIFT_X   = 24'sd0;
  localparam logic signed [SHZ_W-1:0]   RST_SHIFT_Z   = 13'sd0;

  // Transaction payloads
  typedef struct packed {
    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_col;
    logic [DEPTH_W-1:0] depth_mm;
  } dtc_in_t;

  typedef struct packed {
    logic [CRD_W-1:0] colour_row;
    logic [CRD_W-1:0] colour_col;
    logic             hit;
  } dtc_out_t;

  // Control bits that travel with each item
  typedef struct packed {
    logic valid;
    logic miss;
  } dtc_tag_t;

  // Front end to divider
  typedef struct packed {
    dtc_tag_t        tag;
    logic            neg;
    logic [NQ_W-1:0] divd;
    logic [ZU_W-1:0] z;
  } dtc_divd_t;

  // Divider to output stage
  typedef struct packed {
    dtc_tag_t       tag;
    logic           neg;
    logic           ovf;
    logic [Q_W-1:0] q;
  } dtc_quot_t;

endpackage

// ----- rtl/dtc_axis.sv -----
// One axis front end: pixel offset, three multiplies, numerator sum and rounding dividend.
module dtc_axis (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dtc_pkg::dtc_tag_t               tag_i,
  input  logic [dtc_pkg::PIX_W-1:0]       pix_i,
  input  logic [dtc_pkg::DEPTH_W-1:0]     depth_i,
  input  logic [dtc_pkg::ZU_W-1:0]        z_i,
  input  logic [dtc_pkg::CDW-1:0]         centre_d_i,
  input  logic [dtc_pkg::CCW-1:0]         centre_c_i,
  input  logic [dtc_pkg::RATIO_W-1:0]     ratio_i,
  input  logic signed [dtc_pkg::SHX_W-1:0] shift_i,
  output dtc_pkg::dtc_divd_t              divd_o
);
  import dtc_pkg::*;

  // Stage 1: signed offset from the depth principal point
  dtc_tag_t                   s1_tag_q;
  logic signed [OFFS_W-1:0]   s1_offs_q, s1_offs_d;
  logic [DEPTH_W-1:0]         s1_depth_q;
  logic [ZU_W-1:0]            s1_z_q;

  // Stage 2: offset times ratio, colour centre times z
  dtc_tag_t                   s2_tag_q;
  logic signed [PROD_W-1:0]   s2_prod_q, s2_prod_d;
  logic [CZ_W-1:0]            s2_cz_q, s2_cz_d;
  logic [DEPTH_W-1:0]         s2_depth_q;
  logic [ZU_W-1:0]            s2_z_q;

  // Stage 3: times depth
  dtc_tag_t                   s3_tag_q;
  logic signed [PD_W-1:0]     s3_pd_q, s3_pd_d;
  logic [CZ_W-1:0]            s3_cz_q;
  logic [ZU_W-1:0]            s3_z_q;

  // Stage 4: full numerator
  dtc_tag_t                   s4_tag_q;
  logic signed [NUM_W-1:0]    s4_num_q, s4_num_d;
  logic [ZU_W-1:0]            s4_z_q;
  logic signed [NUM_W-1:0]    pd_ext, sh_ext, cz_ext;

  // Stage 5: dividend 2|num| + den
  dtc_divd_t                  s5_q, s5_d;
  logic [DIVD_W-1:0]          two_num, den_ext, divd_full;
  logic                       neg;

  always_comb begin
    s1_offs_d = $signed({1'b0, pix_i, {PT_FRAC{1'b0}}}) - $signed({1'b0, centre_d_i});
    s2_prod_d = s1_offs_q * $signed({1'b0, ratio_i});
    s2_cz_d   = centre_c_i * s1_z_q;
    s3_pd_d   = s2_prod_q * $signed({1'b0, s2_depth_q});
  end

  // Sum the projected offset, the baseline term and the centre term
  always_comb begin
    pd_ext   = NUM_W'(s3_pd_q);
    sh_ext   = $signed({{(NUM_W-SHX_W-RATIO_FRAC){shift_i[SHX_W-1]}}, shift_i,
                        {RATIO_FRAC{1'b0}}});
    cz_ext   = $signed({{(NUM_W-CZ_W-RATIO_FRAC){1'b0}}, s3_cz_q, {RATIO_FRAC{1'b0}}});
    s4_num_d = pd_ext + sh_ext + cz_ext;
  end

  // Fold the sign into one adder: den + 2|num|, then drop the zero low bits of 2*den
  always_comb begin
    neg       = s4_num_q[NUM_W-1];
    two_num   = {s4_num_q, 1'b0};
    den_ext   = DIVD_W'({s4_z_q, {(DEN_SH-1){1'b0}}});
    divd_full = den_ext + (two_num ^ {DIVD_W{neg}}) + DIVD_W'(neg);
    s5_d.tag  = s4_tag_q;
    s5_d.neg  = neg;
    s5_d.divd = divd_full[DIVD_W-1:DEN_SH];
    s5_d.z    = s4_z_q;
  end

  // Advance all stages every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q   <= '0;
      s1_offs_q  <= '0;
      s1_depth_q <= '0;
      s1_z_q     <= '0;
      s2_tag_q   <= '0;
      s2_prod_q  <= '0;
      s2_cz_q    <= '0;
      s2_depth_q <= '0;
      s2_z_q     <= '0;
      s3_tag_q   <= '0;
      s3_pd_q    <= '0;
      s3_cz_q    <= '0;
      s3_z_q     <= '0;
      s4_tag_q   <= '0;
      s4_num_q   <= '0;
      s4_z_q     <= '0;
      s5_q       <= '0;
    end else begin
      s1_tag_q   <= tag_i;
      s1_offs_q  <= s1_offs_d;
      s1_depth_q <= depth_i;
      s1_z_q     <= z_i;
      s2_tag_q   <= s1_tag_q;
      s2_prod_q  <= s2_prod_d;
      s2_cz_q    <= s2_cz_d;
      s2_depth_q <= s1_depth_q;
      s2_z_q     <= s1_z_q;
      s3_tag_q   <= s2_tag_q;
      s3_pd_q    <= s3_pd_d;
      s3_cz_q    <= s2_cz_q;
      s3_z_q     <= s2_z_q;
      s4_tag_q   <= s3_tag_q;
      s4_num_q   <= s4_num_d;
      s4_z_q     <= s3_z_q;
      s5_q       <= s5_d;
    end
  end

  assign divd_o = s5_q;

endmodule

// ----- rtl/dtc_div.sv -----
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
module dtc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtc_pkg::dtc_divd_t divd_i,
  output dtc_pkg::dtc_quot_t quot_o
);
  import dtc_pkg::*;

  typedef struct packed {
    dtc_tag_t         tag;
    logic             neg;
    logic             ovf;
    logic [ZU_W-1:0]  z;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } dstg_t;

  dstg_t            stg_q [0:Q_W];
  dstg_t            stg_d [0:Q_W];
  logic [REM_W-1:0] cand  [0:Q_W-1];

  // Flag quotients that do not fit and keep the low remainder bits
  always_comb begin
    stg_d[0].tag = divd_i.tag;
    stg_d[0].neg = divd_i.neg;
    stg_d[0].ovf = divd_i.divd >= NQ_W'({divd_i.z, {Q_W{1'b0}}});
    stg_d[0].z   = divd_i.z;
    stg_d[0].rem = divd_i.divd[REM_W-1:0];
    stg_d[0].q   = '0;
  end

  // Subtract the shifted divisor where it fits, most significant bit first
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int BitPos = Q_W - 1 - k;
    always_comb begin
      cand[k]    = REM_W'(stg_q[k].z) << BitPos;
      stg_d[k+1] = stg_q[k];
      if (stg_q[k].rem >= cand[k]) begin
        stg_d[k+1].rem       = stg_q[k].rem - cand[k];
        stg_d[k+1].q[BitPos] = 1'b1;
      end
    end
  end

  // Advance every stage
  for (genvar k = 0; k <= Q_W; k++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[k] <= '0;
      end else begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign quot_o.tag = stg_q[Q_W].tag;
  assign quot_o.neg = stg_q[Q_W].neg;
  assign quot_o.ovf = stg_q[Q_W].ovf;
  assign quot_o.q   = stg_q[Q_W].q;

endmodule

// ----- rtl/depth_to_colour_pixel_mapper_core.sv -----
// Top level of the depth-to-colour pixel mapper: registers, lanes and output stage.
//
// Maps one depth pixel (row, column, depth in mm) to the rounded colour image
// pixel that sees the same point, with a hit flag when it lands inside.
// Input: a transaction is taken at each rising edge with start high and busy
// low. busy stays low, so one pixel can enter on every clock.
// Output: every transaction gives exactly one result, shown on res_o for one
// cycle with res_strobe_o high. Results leave in input order, one per cycle
// at most. The 18-stage depth is set by the offset, the three multiplies,
// the numerator sum, the dividend, the restoring divider that yields one
// quotient bit per stage for each axis, and the output register.
// Configuration: plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i), one
// register per index; write it only while no transaction is in flight.
// Reset: asynchronous, active low; registers take their default calibration
// and any transaction in flight is dropped.
// The receiver cannot stall the block; results are never held.
module depth_to_colour_pixel_mapper_core #(
  parameter int COLOUR_COLS = 1920,
  parameter int COLOUR_ROWS = 1080,
  parameter int DEPTH_COLS  = 512,
  parameter int DEPTH_ROWS  = 424
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  dtc_pkg::dtc_in_t                 px_i,
  output logic                             res_strobe_o,
  output dtc_pkg::dtc_out_t                res_o,
  input  logic                             cfg_we_i,
  input  logic [dtc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dtc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import dtc_pkg::*;

  localparam int LAT = FRONT_LAT + DIV_LAT + 1;

  // Calibration registers
  logic [CDW-1:0]            dpt_ctr_x_q, dpt_ctr_y_q;
  logic [CCW-1:0]            clr_ctr_x_q, clr_ctr_y_q;
  logic [RATIO_W-1:0]        ratio_x_q, ratio_y_q;
  logic signed [SHX_W-1:0]   shift_x_q;
  logic signed [SHZ_W-1:0]   shift_z_q;

  logic                      in_acc;
  logic signed [Z_W-1:0]     z;
  dtc_tag_t                  tag_in;
  dtc_divd_t                 divd_x, divd_y;
  dtc_quot_t                 quot_x, quot_y;
  logic                      in_x, in_y, hit;
  dtc_out_t                  res_d, res_q;
  logic                      res_strobe_q;

  // Write calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpt_ctr_x_q <= RST_DPT_CTR_X;
      dpt_ctr_y_q <= RST_DPT_CTR_Y;
      clr_ctr_x_q <= RST_CLR_CTR_X;
      clr_ctr_y_q <= RST_CLR_CTR_Y;
      ratio_x_q   <= RST_RATIO_X;
      ratio_y_q   <= RST_RATIO_Y;
      shift_x_q   <= RST_SHIFT_X;
      shift_z_q   <= RST_SHIFT_Z;
    end else if (cfg_we_i) begin
      case (dtc_reg_e'(cfg_idx_i))
        REG_DPT_CTR_X: dpt_ctr_x_q <= cfg_wdata_i[CDW-1:0];
        REG_DPT_CTR_Y: dpt_ctr_y_q <= cfg_wdata_i[CDW-1:0];
        REG_CLR_CTR_X: clr_ctr_x_q <= cfg_wdata_i[CCW-1:0];
        REG_CLR_CTR_Y: clr_ctr_y_q <= cfg_wdata_i[CCW-1:0];
        REG_RATIO_X:   ratio_x_q   <= cfg_wdata_i[RATIO_W-1:0];
        REG_RATIO_Y:   ratio_y_q   <= cfg_wdata_i[RATIO_W-1:0];
        REG_SHIFT_X:   shift_x_q   <= $signed(cfg_wdata_i[SHX_W-1:0]);
        REG_SHIFT_Z:   shift_z_q   <= $signed(cfg_wdata_i[SHZ_W-1:0]);
        default: ;
      endcase
    end
  end

  // Accept one transaction per cycle
  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  // Shifted depth and the cases that can never hit
  always_comb begin
    z = $signed({2'b00, px_i.depth_mm}) + Z_W'(shift_z_q);
    tag_in.valid = in_acc;
    tag_in.miss  = (px_i.depth_mm == '0) || z[Z_W-1] || (z == '0)
                || ({1'b0, px_i.pixel_col} >= (PIX_W+1)'(DEPTH_COLS))
                || ({1'b0, px_i.pixel_row} >= (PIX_W+1)'(DEPTH_ROWS));
  end

  dtc_axis u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (tag_in),
    .pix_i      (px_i.pixel_col),
    .depth_i    (px_i.depth_mm),
    .z_i        (z[ZU_W-1:0]),
    .centre_d_i (dpt_ctr_x_q),
    .centre_c_i (clr_ctr_x_q),
    .ratio_i    (ratio_x_q),
    .shift_i    (shift_x_q),
    .divd_o     (divd_x)
  );

  dtc_axis u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (tag_in),
    .pix_i      (px_i.pixel_row),
    .depth_i    (px_i.depth_mm),
    .z_i        (z[ZU_W-1:0]),
    .centre_d_i (dpt_ctr_y_q),
    .centre_c_i (clr_ctr_y_q),
    .ratio_i    (ratio_y_q),
    .shift_i    ('0),
    .divd_o     (divd_y)
  );

  dtc_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .divd_i (divd_x),
    .quot_o (quot_x)
  );

  dtc_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .divd_i (divd_y),
    .quot_o (quot_y)
  );

  // Range check: a negative result hits only when it rounds to zero
  always_comb begin
    in_x = quot_x.neg ? (quot_x.q == '0) : ({1'b0, quot_x.q} < (Q_W+1)'(COLOUR_COLS));
    in_y = quot_y.neg ? (quot_y.q == '0) : ({1'b0, quot_y.q} < (Q_W+1)'(COLOUR_ROWS));
    hit  = !quot_x.tag.miss && !quot_y.tag.miss && !quot_x.ovf && !quot_y.ovf
        && in_x && in_y;
    res_d.hit        = hit;
    res_d.colour_col = hit ? quot_x.q : '0;
    res_d.colour_row = hit ? quot_y.q : '0;
  end

  // Register the result and its strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_q <= 1'b0;
      res_q        <= '0;
    end else begin
      res_strobe_q <= quot_x.tag.valid;
      res_q        <= res_d;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  // Both axis lanes carry the same transaction at the same time
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quot_x.tag == quot_y.tag)
    else $error("axis lanes out of step");

  // A result appears only for a transaction taken the pipeline depth earlier
  a_strobe_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(in_acc, LAT))
    else $error("result strobe without matching input transaction");

  // A hit always lies inside the colour image
  a_hit_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.hit) |->
      (({1'b0, res_o.colour_col} < (CRD_W+1)'(COLOUR_COLS))
       && ({1'b0, res_o.colour_row} < (CRD_W+1)'(COLOUR_ROWS))))
    else $error("hit outside colour image");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the depth-to-colour pixel mapper core.
module tb_top;
  import dtc_pkg::*;

  localparam int COLOUR_COLS   = 1920;
  localparam int COLOUR_ROWS   = 1080;
  localparam int DEPTH_COLS    = 512;
  localparam int DEPTH_ROWS    = 424;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_REPORTS   = 10;

  // Calibration as the block holds it
  typedef struct {
    logic [CDW-1:0]            dpt_ctr_x;
    logic [CDW-1:0]            dpt_ctr_y;
    logic [CCW-1:0]            clr_ctr_x;
    logic [CCW-1:0]            clr_ctr_y;
    logic [RATIO_W-1:0]        ratio_x;
    logic [RATIO_W-1:0]        ratio_y;
    logic signed [SHX_W-1:0]   shift_x;
    logic signed [SHZ_W-1:0]   shift_z;
  } calib_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  px_start    = 1'b0;
  logic                  busy;
  dtc_in_t               px_in       = '0;
  logic                  res_strobe_o;
  dtc_out_t              res_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  dtc_in_t  pixel_queue[$];
  dtc_out_t expected_coords[$];
  calib_t   cal_model;
  int       send_gap_pct = 0;
  logic     px_taken     = 1'b0;
  int       mismatch_cnt = 0;
  int       cycle_cnt    = 0;

  depth_to_colour_pixel_mapper_core #(
    .COLOUR_COLS(COLOUR_COLS),
    .COLOUR_ROWS(COLOUR_ROWS),
    .DEPTH_COLS (DEPTH_COLS),
    .DEPTH_ROWS (DEPTH_ROWS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (px_start),
    .busy        (busy),
    .px_i        (px_in),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // One axis in exact integers: Q.16 numerator over z << 16, rounded half away from zero
  function automatic longint project_axis(longint centre_c, longint pix, longint centre_d,
                                          longint ratio, longint shift, longint depth,
                                          longint z);
    longint num, den, mag, quot;
    num  = (pix * 16 - centre_d) * ratio * depth + shift * 4096 + centre_c * 4096 * z;
    den  = z * 65536;
    mag  = (num < 0) ? -num : num;
    quot = (2 * mag + den) / (2 * den);
    return (num < 0) ? -quot : quot;
  endfunction

  // Predict the colour pixel for one depth pixel under the current calibration
  function automatic dtc_out_t map_pixel(dtc_in_t px);
    dtc_out_t res;
    longint   depth, z, u, v;
    res   = '0;
    depth = longint'(px.depth_mm);
    z     = depth + longint'(cal_model.shift_z);
    if (depth == 0 || z <= 0) return res;
    if (px.pixel_col >= DEPTH_COLS || px.pixel_row >= DEPTH_ROWS) return res;
    u = project_axis(longint'(cal_model.clr_ctr_x), longint'(px.pixel_col),
                     longint'(cal_model.dpt_ctr_x), longint'(cal_model.ratio_x),
                     longint'(cal_model.shift_x), depth, z);
    v = project_axis(longint'(cal_model.clr_ctr_y), longint'(px.pixel_row),
                     longint'(cal_model.dpt_ctr_y), longint'(cal_model.ratio_y),
                     0, depth, z);
    if (u < 0 || u >= COLOUR_COLS || v < 0 || v >= COLOUR_ROWS) return res;
    res.colour_row = v[CRD_W-1:0];
    res.colour_col = u[CRD_W-1:0];
    res.hit        = 1'b1;
    return res;
  endfunction

  function automatic dtc_in_t random_pixel();
    dtc_in_t px;
    int      pick;
    pick = $urandom_range(0, 99);
    px.pixel_row = PIX_W'($urandom_range(0, DEPTH_ROWS - 1));
    px.pixel_col = PIX_W'($urandom_range(0, DEPTH_COLS - 1));
    if (pick < 12) begin
      // any value of every field, mostly outside the depth image
      px.pixel_row = PIX_W'($urandom);
      px.pixel_col = PIX_W'($urandom);
      px.depth_mm  = DEPTH_W'($urandom);
    end else if (pick < 16) begin
      px.depth_mm = '0;
    end else if (pick < 40) begin
      // near range, where a depth offset can push z to zero or below
      px.depth_mm = DEPTH_W'($urandom_range(1, 600));
    end else begin
      px.depth_mm = DEPTH_W'($urandom_range(500, 8000));
    end
    return px;
  endfunction

  function automatic calib_t make_calib(int dcx, int dcy, int ccx, int ccy,
                                        int rx, int ry, int shx, int shz);
    calib_t c;
    c.dpt_ctr_x = CDW'(dcx);
    c.dpt_ctr_y = CDW'(dcy);
    c.clr_ctr_x = CCW'(ccx);
    c.clr_ctr_y = CCW'(ccy);
    c.ratio_x   = RATIO_W'(rx);
    c.ratio_y   = RATIO_W'(ry);
    c.shift_x   = SHX_W'(shx);
    c.shift_z   = SHZ_W'(shz);
    return c;
  endfunction

  // Plausible camera pair: centres near mid image, ratios 1..4, modest baseline
  function automatic calib_t random_calib();
    return make_calib($urandom_range(200 * 16, 312 * 16), $urandom_range(150 * 16, 274 * 16),
                      $urandom_range(700 * 16, 1200 * 16), $urandom_range(400 * 16, 700 * 16),
                      $urandom_range(4096, 16384), $urandom_range(4096, 16384),
                      int'($urandom_range(0, 2000000)) - 1000000,
                      int'($urandom_range(0, 600)) - 300);
  endfunction

  // Write one register; bits above the register width carry junk
  task automatic write_reg(dtc_reg_e idx, logic [CFG_DATA_W-1:0] val, int width);
    logic [CFG_DATA_W-1:0] mask, junk;
    mask = {CFG_DATA_W{1'b1}} >> (CFG_DATA_W - width);
    junk = CFG_DATA_W'($urandom);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= (junk & ~mask) | (val & mask);
  endtask

  task automatic load_calib(calib_t c);
    write_reg(REG_DPT_CTR_X, c.dpt_ctr_x, CDW);
    write_reg(REG_DPT_CTR_Y, c.dpt_ctr_y, CDW);
    write_reg(REG_CLR_CTR_X, c.clr_ctr_x, CCW);
    write_reg(REG_CLR_CTR_Y, c.clr_ctr_y, CCW);
    write_reg(REG_RATIO_X, c.ratio_x, RATIO_W);
    write_reg(REG_RATIO_Y, c.ratio_y, RATIO_W);
    write_reg(REG_SHIFT_X, c.shift_x, SHX_W);
    write_reg(REG_SHIFT_Z, c.shift_z, SHZ_W);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_pixel(int row, int col, int depth);
    dtc_in_t px;
    px.pixel_row = row[PIX_W-1:0];
    px.pixel_col = col[PIX_W-1:0];
    px.depth_mm  = depth[DEPTH_W-1:0];
    pixel_queue.push_back(px);
  endtask

  // Wait until every queued pixel is taken and every result is back, then settle
  task automatic drain();
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || px_start || expected_coords.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic feed_random(int count, int gap_pct);
    send_gap_pct = gap_pct;
    repeat (count) pixel_queue.push_back(random_pixel());
    drain();
  endtask

  // Driver: hold a pixel until taken, otherwise idle at random or present the next one
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      px_start <= 1'b0;
    end else if (px_start && !px_taken) begin
      px_start <= 1'b1;
    end else if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
      px_start <= 1'b1;
      px_in    <= pixel_queue.pop_front();
    end else begin
      px_start           <= 1'b0;
      px_in.pixel_row    <= PIX_W'($urandom);
      px_in.pixel_col    <= PIX_W'($urandom);
      px_in.depth_mm     <= DEPTH_W'($urandom);
    end
  end

  // Monitor: predict on each accepted transaction, check each strobed result, track writes
  always @(posedge clk_i) begin
    dtc_out_t want;
    if (!rst_ni) begin
      cal_model.dpt_ctr_x = RST_DPT_CTR_X;
      cal_model.dpt_ctr_y = RST_DPT_CTR_Y;
      cal_model.clr_ctr_x = RST_CLR_CTR_X;
      cal_model.clr_ctr_y = RST_CLR_CTR_Y;
      cal_model.ratio_x   = RST_RATIO_X;
      cal_model.ratio_y   = RST_RATIO_Y;
      cal_model.shift_x   = RST_SHIFT_X;
      cal_model.shift_z   = RST_SHIFT_Z;
    end else begin
      px_taken <= px_start && !busy;
      if (px_start && !busy) expected_coords.push_back(map_pixel(px_in));
      if (res_strobe_o) begin
        if (expected_coords.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result: row %0d col %0d hit %0b",
                     res_o.colour_row, res_o.colour_col, res_o.hit);
        end else begin
          want = expected_coords.pop_front();
          if (res_o.colour_row !== want.colour_row || res_o.colour_col !== want.colour_col ||
              res_o.hit !== want.hit) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display({"result mismatch: expected row %0d col %0d hit %0b, ",
                        "got row %0d col %0d hit %0b"},
                       want.colour_row, want.colour_col, want.hit,
                       res_o.colour_row, res_o.colour_col, res_o.hit);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DPT_CTR_X: cal_model.dpt_ctr_x = cfg_wdata_i[CDW-1:0];
          REG_DPT_CTR_Y: cal_model.dpt_ctr_y = cfg_wdata_i[CDW-1:0];
          REG_CLR_CTR_X: cal_model.clr_ctr_x = cfg_wdata_i[CCW-1:0];
          REG_CLR_CTR_Y: cal_model.clr_ctr_y = cfg_wdata_i[CCW-1:0];
          REG_RATIO_X:   cal_model.ratio_x   = cfg_wdata_i[RATIO_W-1:0];
          REG_RATIO_Y:   cal_model.ratio_y   = cfg_wdata_i[RATIO_W-1:0];
          REG_SHIFT_X:   cal_model.shift_x   = cfg_wdata_i[SHX_W-1:0];
          REG_SHIFT_Z:   cal_model.shift_z   = cfg_wdata_i[SHZ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed pixels under the reset calibration: corners, extremes, no reading, off image
    queue_pixel(0, 0, 1);
    queue_pixel(0, 0, 65535);
    queue_pixel(423, 511, 500);
    queue_pixel(423, 511, 65535);
    queue_pixel(212, 256, 1000);
    queue_pixel(0, 0, 0);
    queue_pixel(423, 511, 0);
    queue_pixel(424, 0, 1000);
    queue_pixel(0, 512, 1000);
    queue_pixel(1023, 1023, 65535);
    queue_pixel(1023, 0, 1000);
    queue_pixel(0, 1023, 1000);
    queue_pixel(212, 0, 4500);
    queue_pixel(0, 256, 4500);
    queue_pixel(423, 256, 800);
    drain();
    feed_random(300, 0);

    // Edge calibration: unit ratios, colour centre at the origin, negative depth offset.
    // Probe rounding just inside and just outside the left edge, and z at or below zero.
    load_calib(make_calib(4096, 3392, 0, 0, 4096, 4096, -3200, -500));
    queue_pixel(212, 256, 1000);
    queue_pixel(212, 256, 900);
    queue_pixel(212, 256, 500);
    queue_pixel(212, 256, 400);
    queue_pixel(211, 256, 1000);
    queue_pixel(212, 257, 1000);
    drain();

    load_calib(random_calib());
    feed_random(300, 61);
    load_calib(make_calib(16383, 16383, 32767, 32767, 65535, 65535, 8388607, 4095));
    feed_random(150, 27);
    load_calib(make_calib(0, 0, 0, 0, 0, 0, -8388608, -4096));
    feed_random(150, 0);
    load_calib(random_calib());
    feed_random(300, 27);
    load_calib(random_calib());
    feed_random(300, 61);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dtc_pkg.sv
rtl/dtc_axis.sv
rtl/dtc_div.sv
rtl/depth_to_colour_pixel_mapper_core.sv
bench/tb_top.sv
